FILE: hdl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open-addressed hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int DEF_SLOTS     = 1024;
  localparam int DEF_KEY_BYTES = 11;
  localparam int MAX_KEY_BYTES = 11;

  localparam int HASH_W  = 32;
  localparam int DIV_W   = 64;
  localparam int SIZE_W  = 11;
  localparam int SLOT_W  = 10;
  localparam int PROBE_W = 11;

  localparam logic [HASH_W-1:0] DJB2_SEED  = 32'd5381;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 11'd1024;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] key_low;
    logic [23:0] key_high;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               found;
    logic [PROBE_W-1:0] probes;
    logic               status;
  } result_t;

endpackage

FILE: hdl/oaht_hash.sv
// ----------------------------------------------------------------------------
// oaht_hash
// Byte-serial djb2 hash, one key byte per cycle, lowest byte first.
// ----------------------------------------------------------------------------
module oaht_hash #(
  parameter int KEY_BYTES = oaht_pkg::DEF_KEY_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [8*KEY_BYTES-1:0]      key,
  output logic                        done,
  output logic [oaht_pkg::HASH_W-1:0] hash
);
  import oaht_pkg::*;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int CNT_W = $clog2(KEY_BYTES + 1);

  logic [KEY_W-1:0] sh;
  logic [CNT_W-1:0] cnt;
  logic             run;

  // Only the low 32 bits of the hash survive, so the sum is kept at 32 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= key;
        hash <= DJB2_SEED;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        hash <= (hash << 5) + hash + HASH_W'(sh[7:0]);
        sh   <= sh >> 8;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(KEY_BYTES - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/oaht_mod.sv
// ----------------------------------------------------------------------------
// oaht_mod
// Bit-serial restoring remainder of a 64-bit word by an 11-bit divisor.
// ----------------------------------------------------------------------------
module oaht_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [oaht_pkg::DIV_W-1:0]  dividend,
  input  logic [oaht_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [oaht_pkg::SIZE_W-1:0] rem
);
  import oaht_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  sh;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [SIZE_W:0]   trial;

  // The remainder stays below the divisor, so the trial fits in one extra bit.
  assign trial = {rem, sh[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh  <= dividend;
        rem <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= SIZE_W'(trial - {1'b0, divisor});
        end else begin
          rem <= SIZE_W'(trial);
        end
        sh  <= sh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/open_address_hash_table.sv
// ----------------------------------------------------------------------------
// open_address_hash_table
// Open-addressed key table with djb2 hashing and quadratic probing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the valid memory with busy high. A word is
// taken when start is high and busy is low; busy then stays high until the
// result is shown on result for the single cycle in which done is high, and
// the receiver must take it then. Each word is hashed, then reduced by the
// serial remainder unit (twice for the first word after reset or after a
// size write), and then probed: each probe is a registered read of the slot
// memory in S_ADDR and a check in S_CHECK, with an S_ADJ step after the
// probe at which the probe sum wraps.
module open_address_hash_table #(
  parameter int SLOTS     = oaht_pkg::DEF_SLOTS,
  parameter int KEY_BYTES = oaht_pkg::DEF_KEY_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  oaht_pkg::item_t             item,
  output logic                        busy,
  output logic                        done,
  output oaht_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [oaht_pkg::SIZE_W-1:0] cfg_wdata
);
  import oaht_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int KEY_W = 8 * KEY_BYTES;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_WMOD, S_HMOD, S_ADDR, S_CHECK, S_ADJ
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   size_cfg;
  logic [SIZE_W-1:0]   size;
  logic                op;
  logic [KEY_W-1:0]    key;
  logic [IDX_W-1:0]    clr_cnt;
  logic                w_ok;
  logic [SIZE_W-1:0]   wrap_mod;
  logic [DIV_W-1:0]    psum;
  logic [SIZE_W-1:0]   r;
  logic [SIZE_W-1:0]   d;
  logic [PROBE_W-1:0]  p;
  logic                wrapped;

  logic                hash_done;
  logic [HASH_W-1:0]   hash;
  logic [DIV_W-1:0]    h_ext;
  logic                div_start;
  logic [DIV_W-1:0]    dividend;
  logic                div_done;
  logic [SIZE_W-1:0]   rem;

  logic                vld_mem [SLOTS];
  logic [KEY_W-1:0]    key_mem [SLOTS];
  logic                vld_q;
  logic [KEY_W-1:0]    key_q;
  logic                mem_we;
  logic [IDX_W-1:0]    rd_addr;

  logic [SIZE_W:0]     p_inc;
  logic [SIZE_W+1:0]   step;
  logic [DIV_W:0]      psum_next;
  logic [SIZE_W:0]     r_add;
  logic [SIZE_W-1:0]   r_next;
  logic [SIZE_W:0]     d_add;
  logic [SIZE_W-1:0]   d_next;
  logic [SIZE_W:0]     w_add;

  always_comb begin
    if (size_cfg == '0) begin
      size = SIZE_W'(1);
    end else if (32'(size_cfg) > SLOTS) begin
      size = SIZE_W'(SLOTS);
    end else begin
      size = size_cfg;
    end
  end

  assign busy    = (state != S_IDLE);
  assign h_ext   = {{(DIV_W - HASH_W){hash[HASH_W-1]}}, hash};
  assign rd_addr = IDX_W'(r);
  assign mem_we  = (state == S_CHECK) && !vld_q && (op == OP_INSERT);

  oaht_hash #(
    .KEY_BYTES(KEY_BYTES)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(start && !busy),
    .key  (KEY_W'({item.key_high, item.key_low})),
    .done (hash_done),
    .hash (hash)
  );

  // Unless 2^64 mod size is already held, the remainder unit first yields it
  // (from all ones, plus one), then the hash mod size.
  always_comb begin
    div_start = 1'b0;
    dividend  = h_ext;
    if (state == S_HASH && hash_done) begin
      div_start = 1'b1;
      dividend  = w_ok ? h_ext : '1;
    end else if (state == S_WMOD && div_done) begin
      div_start = 1'b1;
    end
  end

  oaht_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (size),
    .done    (div_done),
    .rem     (rem)
  );

  // Probe p+1 lies 2(p+1) past probe p; the step and the slot are kept mod size.
  assign p_inc     = {1'b0, p} + 1'b1;
  assign step      = {p_inc, 1'b0};
  assign psum_next = {1'b0, psum} + (DIV_W + 1)'(step);
  assign r_add     = {1'b0, r} + {1'b0, d};
  assign r_next    = (r_add >= {1'b0, size}) ? SIZE_W'(r_add - {1'b0, size}) : SIZE_W'(r_add);
  assign d_add     = {1'b0, d} + (SIZE_W + 1)'(2);
  assign w_add     = {1'b0, rem} + 1'b1;

  always_comb begin
    if (size == SIZE_W'(1)) begin
      d_next = '0;
    end else if (d_add >= {1'b0, size}) begin
      d_next = SIZE_W'(d_add - {1'b0, size});
    end else begin
      d_next = SIZE_W'(d_add);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      vld_mem[clr_cnt] <= 1'b0;
    end else if (mem_we) begin
      vld_mem[rd_addr] <= 1'b1;
    end
    if (mem_we) begin
      key_mem[rd_addr] <= key;
    end
    vld_q <= vld_mem[rd_addr];
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      size_cfg <= RESET_SIZE;
      w_ok     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        size_cfg <= cfg_wdata;
        w_ok     <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op    <= item.opcode;
            key   <= KEY_W'({item.key_high, item.key_low});
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= w_ok ? S_HMOD : S_WMOD;
          end
        end
        S_WMOD: begin
          if (div_done) begin
            wrap_mod <= (w_add == {1'b0, size}) ? '0 : SIZE_W'(w_add);
            w_ok     <= 1'b1;
            state    <= S_HMOD;
          end
        end
        S_HMOD: begin
          if (div_done) begin
            r     <= rem;
            psum  <= h_ext;
            p     <= '0;
            d     <= (size <= SIZE_W'(2)) ? '0 : SIZE_W'(2);
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!vld_q || (op == OP_LOOKUP && key_q == key)) begin
            result.slot   <= SLOT_W'(r);
            result.found  <= vld_q || (op == OP_INSERT);
            result.probes <= p;
            result.status <= 1'b0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else if (p_inc == {1'b0, size}) begin
            result.slot   <= '0;
            result.found  <= 1'b0;
            result.probes <= size;
            result.status <= 1'b1;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            p       <= PROBE_W'(p_inc);
            psum    <= psum_next[DIV_W-1:0];
            wrapped <= psum_next[DIV_W];
            r       <= r_next;
            d       <= d_next;
            state   <= psum_next[DIV_W] ? S_ADJ : S_ADDR;
          end
        end
        S_ADJ: begin
          // The probe sum passed 2^64, so 2^64 mod size comes off the slot.
          if (wrapped) begin
            r <= (r >= wrap_mod) ? r - wrap_mod : SIZE_W'(r + size - wrap_mod);
          end
          state <= S_ADDR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_ends_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without an item in progress");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (!result.found && result.slot == '0))
    else $error("probe bound result carries a slot or found flag");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("table not being cleared after reset");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (r < size))
    else $error("probe slot outside the table");

endmodule

FILE: tb/sv/oaht_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oaht_checker
// Watches the word and result channels of the hash table, keeps its own copy
// of the table to predict each result, and compares field by field.
// ----------------------------------------------------------------------------
module oaht_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  oaht_pkg::item_t             item,
  input  logic                        done,
  input  oaht_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [oaht_pkg::SIZE_W-1:0] cfg_wdata,
  output int                          errors,
  output int                          pending
);
  import oaht_pkg::*;

  localparam int NSLOT = DEF_SLOTS;

  logic [SIZE_W-1:0] size_reg;
  bit                occupied [NSLOT];
  logic [63:0]       stored_low [NSLOT];
  logic [23:0]       stored_high [NSLOT];
  result_t           expected_q [$];

  assign pending = expected_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] djb2(input item_t w);
    logic [63:0] h;
    logic [87:0] bytes_all;
    h = 64'd5381;
    bytes_all = {w.key_high, w.key_low};
    for (int i = 0; i < DEF_KEY_BYTES; i++)
      h = h * 64'd33 + 64'(bytes_all[8*i +: 8]);
    return {{32{h[31]}}, h[31:0]};
  endfunction

  // Walks the probe sequence and updates the table on an insert.
  function automatic result_t probe_table(input item_t w);
    result_t r;
    logic [63:0] h, sz, p, idx;
    sz = size_reg;
    if (sz == 0) sz = 1;
    if (sz > NSLOT) sz = NSLOT;
    h = djb2(w);
    for (p = 0; p < sz; p++) begin
      idx = (h + p + p * p) % sz;
      if (!occupied[idx]) begin
        if (w.opcode == OP_INSERT) begin
          occupied[idx] = 1'b1;
          stored_low[idx] = w.key_low;
          stored_high[idx] = w.key_high;
        end
        r.slot = idx[SLOT_W-1:0];
        r.found = (w.opcode == OP_INSERT);
        r.probes = p[PROBE_W-1:0];
        r.status = 1'b0;
        return r;
      end
      if (w.opcode == OP_LOOKUP && stored_low[idx] == w.key_low &&
          stored_high[idx] == w.key_high) begin
        r.slot = idx[SLOT_W-1:0];
        r.found = 1'b1;
        r.probes = p[PROBE_W-1:0];
        r.status = 1'b0;
        return r;
      end
    end
    r.slot = '0;
    r.found = 1'b0;
    r.probes = sz[PROBE_W-1:0];
    r.status = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      size_reg <= RESET_SIZE;
      for (int i = 0; i < NSLOT; i++) occupied[i] = 1'b0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("[%0t] result word with nothing expected", $realtime);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (result.slot !== want.slot)
            report("slot", 64'(result.slot), 64'(want.slot));
          if (result.found !== want.found)
            report("found", 64'(result.found), 64'(want.found));
          if (result.probes !== want.probes)
            report("probes", 64'(result.probes), 64'(want.probes));
          if (result.status !== want.status)
            report("status", 64'(result.status), 64'(want.status));
        end
      end
      if (start && !busy) expected_q.push_back(probe_table(item));
      if (cfg_we) size_reg <= cfg_wdata;
    end
  end
endmodule

FILE: tb/sv/tb_open_address_hash_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_open_address_hash_table
// Drives inserts and lookups through several table sizes with random gaps;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_open_address_hash_table;
  import oaht_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  item_t             item = '0;
  logic              busy, done;
  result_t           result;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  int                errors, pending;
  int                gap_pct;
  longint            cycle_count = 0;
  item_t             key_pool [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 25000000) begin
      $display("tb_open_address_hash_table: done, errors");
      $finish;
    end
  end

  open_address_hash_table u_top (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  oaht_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // Sends one word, with a random gap before it at the current idle rate.
  // Start stays high after the word is taken; the block is busy by then.
  task automatic send_word(input item_t w);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits out every pending result, then lets the probe walk settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic item_t random_key(input logic op);
    item_t w;
    w.opcode = op;
    w.key_low = {$urandom(), $urandom()};
    w.key_high = 24'($urandom());
    return w;
  endfunction

  // Inserts, some of them duplicates, lookups of keys already inserted, and some misses.
  task automatic random_phase(input int count);
    item_t w;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 40 || key_pool.size() == 0) begin
        w = random_key(OP_INSERT);
        if ($urandom_range(9) == 0 && key_pool.size() != 0)
          w = key_pool[$urandom_range(key_pool.size() - 1)];
        w.opcode = OP_INSERT;
        key_pool.push_back(w);
      end else if (sel < 85) begin
        w = key_pool[$urandom_range(key_pool.size() - 1)];
        // A single flipped bit gives a near miss.
        if ($urandom_range(7) == 0) w.key_low[$urandom_range(63)] ^= 1'b1;
      end else begin
        w = random_key(OP_LOOKUP);
      end
      if (sel >= 40) w.opcode = OP_LOOKUP;
      send_word(w);
    end
  endtask

  initial begin
    item_t w;
    gap_pct = 24;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes of the key and both operations on the full table.
    w = '0;                                   send_word(w);
    w.opcode = OP_LOOKUP;                     send_word(w);
    w = '1; w.opcode = OP_INSERT;             send_word(w);
    w.opcode = OP_LOOKUP;                     send_word(w);
    w = '0; w.opcode = OP_INSERT;             send_word(w);
    w.opcode = OP_LOOKUP; w.key_high = 24'h1; send_word(w);
    // Size 1: second insert hits the probe bound.
    write_size(11'd1);
    w = '0;                                   send_word(w);
    w.key_low = 64'h5;                        send_word(w);
    w.opcode = OP_LOOKUP;                     send_word(w);
    // Size 0 acts as 1, out-of-range size acts as the full table.
    write_size(11'd0);
    w.opcode = OP_LOOKUP; w.key_low = '0;     send_word(w);
    write_size(11'd2047);
    w = '1; w.opcode = OP_LOOKUP;             send_word(w);
    // Small tables fill up and exercise duplicates and the probe bound.
    write_size(11'd3);
    for (int i = 0; i < 5; i++) begin
      w = random_key(OP_INSERT); send_word(w); w.opcode = OP_LOOKUP; send_word(w);
    end
    write_size(11'd7);
    random_phase(300);
    write_size(11'd1024);
    random_phase(450);
    gap_pct = 83;
    write_size(11'd31);
    random_phase(300);
    write_size(11'd2);
    random_phase(100);
    write_size(11'd1000);
    random_phase(250);
    gap_pct = 0;
    write_size(11'd1024);
    random_phase(430);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_open_address_hash_table: done, clean");
    end else begin
      $display("tb_open_address_hash_table: done, errors");
    end
    $finish;
  end
endmodule

FILE: open_address_hash_table.f
hdl/oaht_pkg.sv
hdl/oaht_hash.sv
hdl/oaht_mod.sv
hdl/open_address_hash_table.sv
tb/sv/oaht_checker.sv
tb/sv/tb_open_address_hash_table.sv
